// File: src/hftt_pkg.sv
// Shared types, codes and constants for the Huffman tree node table.
// No dependencies; imported by every module of the block except hftt_ram.
package hftt_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int NODE_W      = 9;
  localparam int CNT_W       = 10;
  localparam int SC_W        = 10;
  localparam int SYM_W       = 9;

  localparam logic [SC_W-1:0] SC_RESET = 10'd288;

  localparam logic [1:0] FN_WALK  = 2'd0;
  localparam logic [1:0] FN_ADD   = 2'd1;
  localparam logic [1:0] FN_LEAF  = 2'd2;
  localparam logic [1:0] FN_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LEAF    = 3'd1;
  localparam logic [2:0] ST_NODE    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_BOUNDS  = 3'd4;
  localparam logic [2:0] ST_COLLIDE = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  typedef struct packed {
    logic              is_walk;
    logic              is_add;
    logic              is_leaf;
    logic              is_clear;
    logic [NODE_W-1:0] node;
    logic              side;
    logic [SYM_W-1:0]  symbol;
  } item_t;

  function automatic logic [CNT_W-1:0] node_limit(input logic [SC_W-1:0] sc,
                                                  input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] lim;
    lim = (sc == '0) ? '0 : CNT_W'(sc - 1'b1);
    if (lim > cap) lim = cap;
    return lim;
  endfunction

endpackage

// File: src/huffman_tree_table_top.sv
// Huffman decode tree node table: items pass from the input queue via the table
// read and item register to the result register, one at a time, ordered by the
// single write port (read, then write, then zero new node on a successful add).
// Two-entry input queue and one result register decouple the channels.
// Reset: node count 1, root reads as empty, symbol_count 288; table not swept.
// Depends on hftt_pkg, hftt_front, hftt_back, hftt_ram.
module huffman_tree_table_top import hftt_pkg::*; #(
  parameter int SYMBOL_BITS = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SC_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [NODE_W-1:0] in_node,
  input  logic              in_side,
  input  logic [SYM_W-1:0]  in_symbol,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [NODE_W-1:0] out_index
);

  localparam int CAP_INT = (SYMBOL_BITS >= NODE_W) ? TABLE_DEPTH : (1 << SYMBOL_BITS);
  localparam logic [CNT_W-1:0] NODE_CAP = CNT_W'(CAP_INT);

  logic [CNT_W-1:0] limit_r;
  logic             q_valid;
  logic             q_pop;
  item_t            q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= node_limit(SC_RESET, NODE_CAP);
    end else if (cfg_we) begin
      limit_r <= node_limit(cfg_wdata, NODE_CAP);
    end
  end

  hftt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_node   (in_node),
    .in_side   (in_side),
    .in_symbol (in_symbol),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  hftt_back #(.SYMBOL_BITS(SYMBOL_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .limit      (limit_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_index  (out_index)
  );

endmodule

// File: src/hftt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hftt_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/hftt_front.sv
// Input side: decodes the operation of each transfer and queues it.
// Depends on hftt_pkg.
module hftt_front import hftt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [NODE_W-1:0] in_node,
  input  logic              in_side,
  input  logic [SYM_W-1:0]  in_symbol,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_pop
);

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  item_t      dec;

  always_comb begin
    dec.is_walk  = (in_func == FN_WALK);
    dec.is_add   = (in_func == FN_ADD);
    dec.is_leaf  = (in_func == FN_LEAF);
    dec.is_clear = (in_func == FN_CLEAR);
    dec.node     = in_node;
    dec.side     = in_side;
    dec.symbol   = in_symbol;
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_valid);
    count_nxt  = count_r + {1'b0, push} - {1'b0, (q_pop && q_valid)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: src/hftt_back.sv
// Execution side: node table read-modify-write, node count and result register.
// Depends on hftt_pkg and hftt_ram.
module hftt_back import hftt_pkg::*; #(
  parameter int SYMBOL_BITS = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  limit,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [NODE_W-1:0] out_index
);

  localparam int SW = SYMBOL_BITS + 1;
  localparam int EW = 2 * SW;
  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ZERO = 2'd2;

  logic [1:0]        state_r, state_nxt;
  item_t             item_r;
  logic [CNT_W-1:0]  node_count_r;
  logic              root_ok_r;
  logic [NODE_W-1:0] fresh_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [NODE_W-1:0] out_index_r;

  logic [EW-1:0]          rd_data, entry, new_entry;
  logic [SW-1:0]          slot, new_slot;
  logic [SYMBOL_BITS-1:0] slot_val;
  logic [2:0]             st;
  logic [NODE_W-1:0]      idx;
  logic                   do_wr, grow, fire;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;

  hftt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (AW'(q_item.node)),
    .rdata (rd_data)
  );

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign fire  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign entry    = (item_r.node == '0 && !root_ok_r) ? '0 : rd_data;
  assign slot     = item_r.side ? entry[EW-1:SW] : entry[SW-1:0];
  assign slot_val = slot[SW-1:1];

  always_comb begin
    st       = ST_OK;
    idx      = '0;
    do_wr    = 1'b0;
    grow     = 1'b0;
    new_slot = '0;
    if (item_r.is_clear) begin
      st = ST_OK;
    end else if (item_r.is_add && node_count_r >= limit) begin
      st = ST_FULL;
    end else if ({1'b0, item_r.node} >= node_count_r) begin
      st = ST_BOUNDS;
    end else if (item_r.is_walk) begin
      if (slot[0]) begin
        st  = ST_LEAF;
        idx = NODE_W'(slot_val);
      end else if (slot_val == '0) begin
        st = ST_EMPTY;
      end else begin
        st  = ST_NODE;
        idx = NODE_W'(slot_val);
      end
    end else if (slot != '0) begin
      st = ST_COLLIDE;
    end else if (item_r.is_add) begin
      grow     = 1'b1;
      do_wr    = 1'b1;
      new_slot = {SYMBOL_BITS'(node_count_r), 1'b0};
      idx      = NODE_W'(node_count_r);
    end else if (item_r.is_leaf) begin
      do_wr    = 1'b1;
      new_slot = {SYMBOL_BITS'(item_r.symbol), 1'b1};
    end
  end

  assign new_entry = item_r.side ? {new_slot, entry[SW-1:0]} : {entry[EW-1:SW], new_slot};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(item_r.node);
    ram_wdata = new_entry;
    if (state_r == S_ZERO) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(fresh_r);
      ram_wdata = '0;
    end else if (fire && do_wr) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fire) state_nxt = grow ? S_ZERO : S_IDLE;
      end
      S_ZERO: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= CNT_W'(1);
      root_ok_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
        if (item_r.is_clear) begin
          node_count_r <= CNT_W'(1);
          root_ok_r    <= 1'b0;
        end
        if (do_wr && item_r.node == '0) begin
          root_ok_r <= 1'b1;
        end
        if (grow) begin
          node_count_r <= node_count_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (fire) begin
      out_status_r <= st;
      out_index_r  <= idx;
      fresh_r      <= NODE_W'(node_count_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;

endmodule

// File: src/hftt_checker.sv
// Port-level checks for the Huffman tree node table, bound to the top level.
// Depends on hftt_pkg.
module hftt_checker import hftt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_status,
  input logic [NODE_W-1:0] out_index
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_index))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 3'd7)
    else $error("undefined status code");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_BOUNDS ||
                  out_status == ST_COLLIDE || out_status == ST_FULL)
    |-> out_index == '0)
    else $error("index set on failing status");

endmodule

bind huffman_tree_table_top hftt_checker u_hftt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_index  (out_index)
);

// File: sim/huffman_tree_table_top_test.sv
// Self-checking testbench for huffman_tree_table_top: drives tree ops with random stalls,
// predicts every result from a shadow node table and checks replies in order.
// Depends on hftt_pkg and the huffman_tree_table_top RTL.
module huffman_tree_table_top_test import hftt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [2:0]        status;
    logic [NODE_W-1:0] index;
  } reply_t;

  class tree_table_board;
    logic [2*(SYM_W+1)-1:0] nodes [TABLE_DEPTH];
    int nodes_used;
    int symbol_count;
    int errors;
    reply_t replies_due [$];

    function new();
      nodes_used = 1;
      symbol_count = SC_RESET;
      errors = 0;
      foreach (nodes[i]) nodes[i] = '0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function int grow_limit();
      int lim;
      lim = (symbol_count == 0) ? 0 : symbol_count - 1;
      if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
      if (lim > (1 << SYM_W)) lim = 1 << SYM_W;
      return lim;
    endfunction

    function void accept_op(logic [1:0] fn, logic [NODE_W-1:0] nd, logic sd,
                            logic [SYM_W-1:0] sym);
      reply_t r;
      logic [SYM_W:0] slot;
      int fresh;
      r.status = ST_OK;
      r.index = '0;
      if (fn == FN_CLEAR) begin
        nodes_used = 1;
        nodes[0] = '0;
      end else if (fn == FN_ADD && nodes_used >= grow_limit()) begin
        r.status = ST_FULL;
      end else if (nd >= nodes_used) begin
        r.status = ST_BOUNDS;
      end else begin
        slot = sd ? nodes[nd][2*SYM_W+1:SYM_W+1] : nodes[nd][SYM_W:0];
        if (fn == FN_WALK) begin
          if (slot[0]) begin
            r.status = ST_LEAF;
            r.index = slot[SYM_W:1];
          end else if (slot[SYM_W:1] == '0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_NODE;
            r.index = slot[SYM_W:1];
          end
        end else if (slot != '0) begin
          r.status = ST_COLLIDE;
        end else if (fn == FN_ADD) begin
          fresh = nodes_used;
          nodes_used++;
          nodes[fresh] = '0;
          slot = {fresh[SYM_W-1:0], 1'b0};
          if (sd) nodes[nd][2*SYM_W+1:SYM_W+1] = slot;
          else nodes[nd][SYM_W:0] = slot;
          r.index = fresh[NODE_W-1:0];
        end else begin
          slot = {sym, 1'b1};
          if (sd) nodes[nd][2*SYM_W+1:SYM_W+1] = slot;
          else nodes[nd][SYM_W:0] = slot;
        end
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [2:0] st, logic [NODE_W-1:0] idx);
      reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d index %0d", st, idx);
        return;
      end
      want = replies_due.pop_front();
      if (st !== want.status || idx !== want.index) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected status %0d index %0d, got status %0d index %0d",
                   want.status, want.index, st, idx);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [SC_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_func = FN_WALK;
  logic [NODE_W-1:0] in_node = '0;
  logic              in_side = 1'b0;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_status;
  logic [NODE_W-1:0] out_index;

  tree_table_board board = new();
  int sent = 0;
  int drained = 0;
  int hold_left = 0;
  int cycles = 0;
  logic steady;

  assign steady = (sent >= 1000) && (sent < 1250);

  huffman_tree_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_node   (in_node),
    .in_side   (in_side),
    .in_symbol (in_symbol),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_index (out_index)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.accept_op(in_func, in_node, in_side, in_symbol);
    if (rst_n && out_valid && out_ready) board.check_reply(out_status, out_index);
  end

  // hold off once for a long stretch so the input side backs up
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) drained <= drained + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready && drained == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic push_op(input logic [1:0] fn, input logic [NODE_W-1:0] nd, input logic sd,
                         input logic [SYM_W-1:0] sym);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= fn;
    in_node   <= nd;
    in_side   <= sd;
    in_symbol <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_symbol_count(input logic [SC_W-1:0] value);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.symbol_count = value;
  endtask

  task automatic random_phase(input logic [SC_W-1:0] sc, input int n, input int add_pct,
                              input int clear_pct);
    int roll;
    int cnt;
    int nd;
    logic [1:0] fn;
    write_symbol_count(sc);
    repeat (n) begin
      cnt  = board.nodes_used;
      roll = $urandom_range(0, 99);
      nd   = $urandom_range(0, cnt - 1);
      if (roll < clear_pct) begin
        fn = FN_CLEAR;
      end else if (roll < clear_pct + add_pct) begin
        fn = FN_ADD;
        if ($urandom_range(0, 99) < 85) nd = cnt - 1;
      end else if (roll < clear_pct + add_pct + (100 - clear_pct - add_pct) / 2) begin
        fn = FN_LEAF;
      end else begin
        fn = FN_WALK;
      end
      if ($urandom_range(0, 99) < 15) nd = $urandom_range(0, TABLE_DEPTH - 1);
      push_op(fn, nd[NODE_W-1:0], 1'($urandom_range(0, 1)), SYM_W'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_op(FN_WALK,  9'd0,   1'b0, 9'd0);
    push_op(FN_WALK,  9'd0,   1'b1, 9'd0);
    push_op(FN_LEAF,  9'd0,   1'b0, 9'd511);
    push_op(FN_WALK,  9'd0,   1'b0, 9'd0);
    push_op(FN_ADD,   9'd0,   1'b1, 9'd0);
    push_op(FN_WALK,  9'd0,   1'b1, 9'd0);
    push_op(FN_ADD,   9'd0,   1'b0, 9'd0);
    push_op(FN_LEAF,  9'd0,   1'b1, 9'd0);
    push_op(FN_WALK,  9'd1,   1'b0, 9'd0);
    push_op(FN_LEAF,  9'd1,   1'b1, 9'd0);
    push_op(FN_WALK,  9'd1,   1'b1, 9'd0);
    push_op(FN_WALK,  9'd2,   1'b0, 9'd0);
    push_op(FN_ADD,   9'd511, 1'b1, 9'd0);
    push_op(FN_LEAF,  9'd511, 1'b0, 9'd511);
    push_op(FN_ADD,   9'd1,   1'b0, 9'd0);
    push_op(FN_CLEAR, 9'd511, 1'b1, 9'd511);
    push_op(FN_WALK,  9'd0,   1'b1, 9'd0);
    push_op(FN_WALK,  9'd1,   1'b0, 9'd0);

    write_symbol_count(10'd2);
    push_op(FN_ADD,   9'd0,   1'b0, 9'd0);
    push_op(FN_ADD,   9'd511, 1'b1, 9'd0);
    push_op(FN_LEAF,  9'd0,   1'b0, 9'd5);
    push_op(FN_WALK,  9'd0,   1'b0, 9'd0);

    write_symbol_count(10'd3);
    push_op(FN_ADD,   9'd0,   1'b1, 9'd0);
    push_op(FN_ADD,   9'd1,   1'b0, 9'd0);

    random_phase(10'd512, 750, 80, 0);
    random_phase(10'd2,   150, 30, 3);
    random_phase(10'd17,  150, 30, 3);
    random_phase(10'd300, 150, 35, 2);
    random_phase(10'd3,   150, 30, 3);
    random_phase(10'd511, 150, 35, 2);
    random_phase(10'd129, 150, 35, 2);
    random_phase(SC_RESET, 150, 30, 2);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/hftt_pkg.sv
src/hftt_ram.sv
src/hftt_front.sv
src/hftt_back.sv
src/huffman_tree_table_top.sv
src/hftt_checker.sv
sim/huffman_tree_table_top_test.sv
